>>> rtl/lwmsb_pkg.sv
`default_nettype none
package lwmsb_pkg;
    localparam int VAL_W  = 30;
    localparam int BUD_W  = 33;
    localparam int USED_W = 3;
    localparam int LEN_W  = 11;
    localparam int NCOL   = 5;

    localparam logic CFG_BUDGET = 1'b0;
    localparam logic CFG_COLS   = 1'b1;

    typedef struct packed {
        logic [NCOL-1:0][VAL_W-1:0] values;
        logic                       last;
    } t_row;

    typedef struct packed {
        logic [NCOL-1:0][VAL_W-1:0] maxima;
        logic [LEN_W-1:0]           length;
        logic                       ovf;
    } t_res;
endpackage
`default_nettype wire

>>> rtl/lwmsb_front.sv
`default_nettype none
module lwmsb_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              push,
    output logic             full,
    input  lwmsb_pkg::t_row  i_row,
    input  wire              i_take,
    output logic             o_avail,
    output lwmsb_pkg::t_row  o_row
);
    import lwmsb_pkg::*;

    // two-entry row queue between intake and the window engine
    t_row       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_in, w_out;

    assign full    = (r_cnt == 2'd2);
    assign o_avail = (r_cnt != 2'd0);
    assign o_row   = r_mem[r_rp];
    assign w_in    = push && !full;
    assign w_out   = i_take && o_avail;

    always_ff @(posedge i_clk) begin
        if (w_in) begin
            r_mem[r_wp] <= i_row;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_in) r_wp <= ~r_wp;
            if (w_out) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_in) - 2'(w_out);
        end
    end
endmodule
`default_nettype wire

>>> rtl/lwmsb_back.sv
`default_nettype none
module lwmsb_back #(
    parameter int MAX_ROWS = 1024,
    parameter int COLUMNS  = 5
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire                          i_cfg_idx,
    input  wire [lwmsb_pkg::BUD_W-1:0]   i_cfg_data,
    input  wire                          i_avail,
    input  lwmsb_pkg::t_row              i_row,
    output logic                         o_take,
    output logic                         o_res_valid,
    output lwmsb_pkg::t_res              o_res,
    input  wire                          i_res_pop
);
    import lwmsb_pkg::*;

    localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = $clog2(MAX_ROWS + 1);
    localparam int EW = AW + VAL_W;

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_POP, S_HRD, S_SUM, S_CMP, S_FIN
    } t_state;

    t_state             r_state;
    logic [BUD_W-1:0]   r_budget;
    logic [USED_W-1:0]  r_cols;
    t_row               r_row;
    logic [USED_W-1:0]  r_used;
    logic [CW-1:0]      r_head [COLUMNS];
    logic [CW-1:0]      r_tail [COLUMNS];
    logic [CW-1:0]      r_start, r_rows, r_best_len;
    logic [VAL_W-1:0]   r_best [NCOL];
    logic               r_ovf;
    logic [VAL_W-1:0]   r_max [COLUMNS];
    logic [BUD_W-1:0]   r_sum;
    logic               r_out_valid;
    t_res               r_out;

    logic [EW-1:0]      w_rd_tail [COLUMNS];
    logic [EW-1:0]      w_rd_head [COLUMNS];
    logic [COLUMNS-1:0] w_pop;
    logic               w_any_pop;
    logic               w_we;
    logic [USED_W-1:0]  w_used;
    logic [CW-1:0]      w_len;
    logic               w_over;
    logic               w_emit;

    // per-column monotonic max queue, entries hold {value, row index}
    for (genvar c = 0; c < COLUMNS; c++) begin : g_lane
        logic [EW-1:0] mem [MAX_ROWS];
        logic [EW-1:0] r_qt, r_qh;
        always_ff @(posedge i_clk) begin
            if (w_we) begin
                mem[r_tail[c][AW-1:0]] <= {r_row.values[c], r_rows[AW-1:0]};
            end
            r_qt <= mem[AW'(r_tail[c] - CW'(1))];
            r_qh <= mem[r_head[c][AW-1:0]];
        end
        assign w_rd_tail[c] = r_qt;
        assign w_rd_head[c] = r_qh;
        assign w_pop[c] = (r_tail[c] > r_head[c]) &&
                          (w_rd_tail[c][EW-1:AW] <= r_row.values[c]);
    end

    assign w_any_pop = |w_pop;
    assign w_we      = (r_state == S_POP) && !w_any_pop;
    assign w_len     = r_rows - r_start;
    assign w_over    = (r_start < r_rows) && (r_sum > r_budget);
    assign w_emit    = (r_state == S_FIN) && r_row.last && (!r_out_valid || i_res_pop);
    assign o_take    = (r_state == S_IDLE) && i_avail;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    always_comb begin
        if (r_cols == '0) w_used = USED_W'(1);
        else if (r_cols > USED_W'(COLUMNS)) w_used = USED_W'(COLUMNS);
        else w_used = r_cols;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_budget    <= '0;
            r_cols      <= USED_W'(5);
            r_start     <= '0;
            r_rows      <= '0;
            r_best_len  <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < COLUMNS; c++) begin
                r_head[c] <= '0;
                r_tail[c] <= '0;
            end
            for (int c = 0; c < NCOL; c++) r_best[c] <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_BUDGET: r_budget <= i_cfg_data;
                    CFG_COLS:   r_cols   <= i_cfg_data[USED_W-1:0];
                    default: ;
                endcase
            end
            if (w_emit) r_out_valid <= 1'b1;
            else if (i_res_pop) r_out_valid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (i_avail) begin
                        r_row  <= i_row;
                        r_used <= w_used;
                        if (r_rows == CW'(MAX_ROWS)) begin
                            r_ovf   <= 1'b1;
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: r_state <= S_POP;
                S_POP: begin
                    if (w_any_pop) begin
                        for (int c = 0; c < COLUMNS; c++)
                            if (w_pop[c]) r_tail[c] <= r_tail[c] - CW'(1);
                        r_state <= S_RD;
                    end else begin
                        for (int c = 0; c < COLUMNS; c++)
                            r_tail[c] <= r_tail[c] + CW'(1);
                        r_rows  <= r_rows + CW'(1);
                        r_state <= S_HRD;
                    end
                end
                S_HRD: r_state <= S_SUM;
                S_SUM: begin
                    logic [BUD_W-1:0] s;
                    s = '0;
                    for (int c = 0; c < COLUMNS; c++) begin
                        if (r_head[c] < r_tail[c] && USED_W'(c) < r_used) begin
                            r_max[c] <= w_rd_head[c][EW-1:AW];
                            s = s + BUD_W'(w_rd_head[c][EW-1:AW]);
                        end else begin
                            r_max[c] <= '0;
                        end
                    end
                    r_sum   <= s;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (w_over) begin
                        // drop oldest row, advance heads that point at it
                        for (int c = 0; c < COLUMNS; c++)
                            if (r_head[c] < r_tail[c] &&
                                w_rd_head[c][AW-1:0] == r_start[AW-1:0])
                                r_head[c] <= r_head[c] + CW'(1);
                        r_start <= r_start + CW'(1);
                        r_state <= S_HRD;
                    end else begin
                        if (w_len > r_best_len) begin
                            r_best_len <= w_len;
                            for (int c = 0; c < COLUMNS; c++) r_best[c] <= r_max[c];
                        end
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_row.last) begin
                        r_state <= S_IDLE;
                    end else if (w_emit) begin
                        for (int c = 0; c < NCOL; c++) begin
                            r_out.maxima[c] <= r_best[c];
                            r_best[c]       <= '0;
                        end
                        r_out.length <= LEN_W'(r_best_len);
                        r_out.ovf    <= r_ovf;
                        r_start      <= '0;
                        r_rows       <= '0;
                        r_best_len   <= '0;
                        r_ovf        <= 1'b0;
                        for (int c = 0; c < COLUMNS; c++) begin
                            r_head[c] <= '0;
                            r_tail[c] <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> rtl/longest_window_max_sum_budget.sv
// steps: a row passes S_IDLE, then S_RD and S_POP once per entry popped from the
// column max queues and once more, then S_HRD, S_SUM and S_CMP once per oldest row
// dropped and once more, then S_FIN; a row past capacity goes from S_IDLE to S_FIN;
// the result is registered in the last row's S_FIN and waits while the previous
// result is unread; a new row is taken from the front queue only in S_IDLE, so the
// engine finishes a row before it takes the next; reset: synchronous active-low
// i_rst_n clears the run state, empties both queues, sets budget 0, columns_used 5
`default_nettype none
module longest_window_max_sum_budget #(
    parameter int MAX_ROWS = 1024,
    parameter int COLUMNS  = 5
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire                          i_cfg_idx,
    input  wire [lwmsb_pkg::BUD_W-1:0]   i_cfg_data,
    input  wire                          push,
    output logic                         full,
    input  wire [lwmsb_pkg::VAL_W-1:0]   i_value_0,
    input  wire [lwmsb_pkg::VAL_W-1:0]   i_value_1,
    input  wire [lwmsb_pkg::VAL_W-1:0]   i_value_2,
    input  wire [lwmsb_pkg::VAL_W-1:0]   i_value_3,
    input  wire [lwmsb_pkg::VAL_W-1:0]   i_value_4,
    input  wire                          i_last_row,
    output logic                         empty,
    input  wire                          pop,
    output logic [lwmsb_pkg::VAL_W-1:0]  o_best_max_0,
    output logic [lwmsb_pkg::VAL_W-1:0]  o_best_max_1,
    output logic [lwmsb_pkg::VAL_W-1:0]  o_best_max_2,
    output logic [lwmsb_pkg::VAL_W-1:0]  o_best_max_3,
    output logic [lwmsb_pkg::VAL_W-1:0]  o_best_max_4,
    output logic [lwmsb_pkg::LEN_W-1:0]  o_best_length,
    output logic                         o_overflow
);
    import lwmsb_pkg::*;

    t_row w_in_row, w_q_row;
    t_res w_res;
    logic w_avail, w_take, w_res_valid;

    assign w_in_row.values = {i_value_4, i_value_3, i_value_2, i_value_1, i_value_0};
    assign w_in_row.last   = i_last_row;

    lwmsb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_row   (w_in_row),
        .i_take  (w_take),
        .o_avail (w_avail),
        .o_row   (w_q_row)
    );

    lwmsb_back #(
        .MAX_ROWS (MAX_ROWS),
        .COLUMNS  (COLUMNS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_avail     (w_avail),
        .i_row       (w_q_row),
        .o_take      (w_take),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_pop   (pop)
    );

    assign empty         = !w_res_valid;
    assign o_best_max_0  = w_res.maxima[0];
    assign o_best_max_1  = w_res.maxima[1];
    assign o_best_max_2  = w_res.maxima[2];
    assign o_best_max_3  = w_res.maxima[3];
    assign o_best_max_4  = w_res.maxima[4];
    assign o_best_length = w_res.length;
    assign o_overflow    = w_res.ovf;
endmodule
`default_nettype wire
